[rtl/ebv_pkg.sv]
// ebv_pkg: item types, CORDIC constants and fixed-point helpers shared by
// the orientation pipeline. No dependencies.
package ebv_pkg;

	typedef struct packed {
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic signed [15:0] roll;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] forward_x;
		logic signed [15:0] forward_y;
		logic signed [15:0] forward_z;
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} basis_t;

	// one CORDIC lane: Q30 x/y, binary-angle z, pending sign flip
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               neg;
	} cordic_t;

	localparam int MAX_STAGES = 32;
	localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
	localparam int DEG360_Q6 = 23040;
	localparam int FRAC_ROWS = 45;
	// floor(r * 2^16 / 45) from below; error under one
	localparam logic [10:0] RECIP45 = 11'd1456;

	typedef logic signed [31:0] atan_tbl_t [MAX_STAGES];
	localparam atan_tbl_t ATAN_TBL = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
		32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
		32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
		32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
		32'sd652, 32'sd326, 32'sd163, 32'sd81,
		32'sd41, 32'sd20, 32'sd10, 32'sd5,
		32'sd3, 32'sd1, 32'sd1, 32'sd0
	};

	// low 23 bits of the binary angle for remainder rem of r / 45
	typedef logic [22:0] frac_tbl_t [FRAC_ROWS];

	function automatic frac_tbl_t build_frac_tbl();
		frac_tbl_t t;
		for (int i = 0; i < FRAC_ROWS; i++) begin
			t[i] = 23'((longint'(i) * 64'sd8388608 + 64'sd22) / 45);
		end
		return t;
	endfunction

	// Q30 x Q30, rounded half up to Q30
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

endpackage

[rtl/ebv_angle_prep.sv]
// ebv_angle_prep: two-stage wrap of a Q10.6 degree angle to a folded binary
// angle ready for the CORDIC row. Uses ebv_pkg.
module ebv_angle_prep (
	input  logic                 clk,
	input  logic                 en_s1,
	input  logic                 en_s2,
	input  logic signed [15:0]   angle,
	output ebv_pkg::cordic_t     lane
);
	import ebv_pkg::*;

	localparam frac_tbl_t FRAC_TBL = build_frac_tbl();

	logic signed [16:0] a_ext;
	logic [14:0]        r_wrap;
	logic [25:0]        q_prod;
	logic [14:0]        r_s1;
	logic [8:0]         q0_s1;
	logic [15:0]        rem0;
	logic [8:0]         q_fix;
	logic [5:0]         rem;
	logic signed [32:0] z_ext;
	logic signed [32:0] z_fold;
	logic               neg;

	always_comb begin
		a_ext = 17'(angle);
		if (a_ext < 0) begin
			if (a_ext + 17'sd23040 < 0) begin
				r_wrap = 15'(a_ext + 17'sd46080);
			end else begin
				r_wrap = 15'(a_ext + 17'sd23040);
			end
		end else if (a_ext >= 17'sd23040) begin
			r_wrap = 15'(a_ext - 17'sd23040);
		end else begin
			r_wrap = 15'(a_ext);
		end
		q_prod = 26'(r_wrap) * 26'(RECIP45);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1  <= r_wrap;
			q0_s1 <= q_prod[24:16];
		end
	end

	always_comb begin
		rem0 = 16'(r_s1) - 16'(q0_s1) * 16'd45;
		if (rem0 >= 16'd45) begin
			q_fix = q0_s1 + 9'd1;
			rem   = 6'(rem0 - 16'd45);
		end else begin
			q_fix = q0_s1;
			rem   = 6'(rem0);
		end
		z_ext = 33'(signed'({q_fix, FRAC_TBL[rem]}));
		// beyond +/-90 deg: turn by 180 deg, flip sin/cos afterwards
		if (z_ext > 33'sd1073741824) begin
			z_fold = z_ext - 33'sd2147483648;
			neg    = 1'b1;
		end else if (z_ext < -33'sd1073741824) begin
			z_fold = z_ext + 33'sd2147483648;
			neg    = 1'b1;
		end else begin
			z_fold = z_ext;
			neg    = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			lane.x   <= GAIN_Q30;
			lane.y   <= '0;
			lane.z   <= z_fold[31:0];
			lane.neg <= neg;
		end
	end

endmodule

[rtl/ebv_cordic_cell.sv]
// ebv_cordic_cell: one rotation-mode CORDIC micro-rotation with its output
// register. Uses ebv_pkg.
module ebv_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  logic             en,
	input  ebv_pkg::cordic_t lane_in,
	output ebv_pkg::cordic_t lane_out
);
	import ebv_pkg::*;

	logic signed [31:0] dx;
	logic signed [31:0] dy;

	assign dx = lane_in.y >>> STAGE;
	assign dy = lane_in.x >>> STAGE;

	always_ff @(posedge clk) begin
		if (en) begin
			lane_out.neg <= lane_in.neg;
			if (lane_in.z >= 0) begin
				lane_out.x <= lane_in.x - dx;
				lane_out.y <= lane_in.y + dy;
				lane_out.z <= lane_in.z - ATAN_TBL[STAGE];
			end else begin
				lane_out.x <= lane_in.x + dx;
				lane_out.y <= lane_in.y - dy;
				lane_out.z <= lane_in.z + ATAN_TBL[STAGE];
			end
		end
	end

endmodule

[rtl/ebv_basis.sv]
// ebv_basis: three-stage product, sum and output rounding network that turns
// the six sines/cosines into the nine basis components. Uses ebv_pkg.
module ebv_basis #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             en_s1,
	input  logic             en_s2,
	input  logic             en_s3,
	input  ebv_pkg::cordic_t p_lane,
	input  ebv_pkg::cordic_t y_lane,
	input  ebv_pkg::cordic_t r_lane,
	output ebv_pkg::basis_t  basis
);
	import ebv_pkg::*;

	localparam int SH = 30 - OUT_FRAC_BITS;
	localparam logic signed [33:0] HALF =
		(SH == 0) ? 34'sd0 : (34'sd1 <<< (SH > 0 ? SH - 1 : 0));
	localparam logic signed [33:0] ONE = 34'sd1 <<< OUT_FRAC_BITS;

	function automatic logic [15:0] to_out(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + HALF) >>> SH;
		if (t > ONE) begin
			t = ONE;
		end
		if (t < -ONE) begin
			t = -ONE;
		end
		return t[15:0];
	endfunction

	logic signed [31:0] sp, cp, sy, cy, sr, cr;

	always_comb begin
		sp = p_lane.neg ? -p_lane.y : p_lane.y;
		cp = p_lane.neg ? -p_lane.x : p_lane.x;
		sy = y_lane.neg ? -y_lane.y : y_lane.y;
		cy = y_lane.neg ? -y_lane.x : y_lane.x;
		sr = r_lane.neg ? -r_lane.y : r_lane.y;
		cr = r_lane.neg ? -r_lane.x : r_lane.x;
	end

	logic signed [31:0] srsp_s1, crsp_s1, cpcy_s1, cpsy_s1, sp_s1, srcp_s1, crcp_s1;
	logic signed [31:0] crsy_s1, crcy_s1, srsy_s1, srcy_s1, sy_s1, cy_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			srsp_s1 <= qmul(sr, sp);
			crsp_s1 <= qmul(cr, sp);
			cpcy_s1 <= qmul(cp, cy);
			cpsy_s1 <= qmul(cp, sy);
			srcp_s1 <= qmul(sr, cp);
			crcp_s1 <= qmul(cr, cp);
			crsy_s1 <= qmul(cr, sy);
			crcy_s1 <= qmul(cr, cy);
			srsy_s1 <= qmul(sr, sy);
			srcy_s1 <= qmul(sr, cy);
			sp_s1   <= sp;
			sy_s1   <= sy;
			cy_s1   <= cy;
		end
	end

	logic signed [31:0] t1_s2, t2_s2, t3_s2, t4_s2;
	logic signed [31:0] cpcy_s2, cpsy_s2, sp_s2, srcp_s2, crcp_s2;
	logic signed [31:0] crsy_s2, crcy_s2, srsy_s2, srcy_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			t1_s2   <= qmul(srsp_s1, cy_s1);
			t2_s2   <= qmul(srsp_s1, sy_s1);
			t3_s2   <= qmul(crsp_s1, cy_s1);
			t4_s2   <= qmul(crsp_s1, sy_s1);
			cpcy_s2 <= cpcy_s1;
			cpsy_s2 <= cpsy_s1;
			sp_s2   <= sp_s1;
			srcp_s2 <= srcp_s1;
			crcp_s2 <= crcp_s1;
			crsy_s2 <= crsy_s1;
			crcy_s2 <= crcy_s1;
			srsy_s2 <= srsy_s1;
			srcy_s2 <= srcy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			basis.forward_x <= to_out(34'(cpcy_s2));
			basis.forward_y <= to_out(34'(cpsy_s2));
			basis.forward_z <= to_out(-34'(sp_s2));
			basis.right_x   <= to_out(34'(crsy_s2) - 34'(t1_s2));
			basis.right_y   <= to_out(-34'(t2_s2) - 34'(crcy_s2));
			basis.right_z   <= to_out(-34'(srcp_s2));
			basis.up_x      <= to_out(34'(t3_s2) + 34'(srsy_s2));
			basis.up_y      <= to_out(34'(t4_s2) - 34'(srcy_s2));
			basis.up_z      <= to_out(34'(crcp_s2));
		end
	end

endmodule

[rtl/euler_to_basis_vectors.sv]
// euler_to_basis_vectors: top level of the orientation pipeline.
// Depends on ebv_pkg, ebv_angle_prep, ebv_cordic_cell and ebv_basis.

// Takes one item per cycle while angles_stall is low: pitch, yaw and roll in
// signed Q10.6 degrees, and returns the forward, right and up unit vectors as
// nine signed components with OUT_FRAC_BITS fraction bits (Q2.14 by default),
// saturated at +/-1.0. Stages: 2 angle wrap stages, one CORDIC cell per stage,
// 3 product/rounding stages; throughput is one item per clock while basis_stall
// is low, set by the fully pipelined cell chain. Each stage holds its item until
// the next stage frees, so gaps in the stream are squeezed out while the output
// is stalled. No state is kept between items.
module euler_to_basis_vectors #(
	parameter int CORDIC_STAGES = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             angles_valid,
	output logic             angles_stall,
	input  ebv_pkg::angles_t angles,
	output logic             basis_valid,
	input  logic             basis_stall,
	output ebv_pkg::basis_t  basis
);
	import ebv_pkg::*;

	localparam int DEPTH = CORDIC_STAGES + 5;

	// stage map: 0,1 angle wrap; 2..N+1 cells; N+2..N+4 products/output
	logic [DEPTH-1:0] valid_q;
	logic [DEPTH:0]   en;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		en[DEPTH] = !basis_stall;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			en[i] = !valid_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[0]) begin
				valid_q[0] <= angles_valid;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign angles_stall = !en[0];
	assign basis_valid  = valid_q[DEPTH-1];

	cordic_t p_row [CORDIC_STAGES+1];
	cordic_t y_row [CORDIC_STAGES+1];
	cordic_t r_row [CORDIC_STAGES+1];

	ebv_angle_prep u_prep_p (
		.clk(clk), .en_s1(en[0]), .en_s2(en[1]), .angle(angles.pitch), .lane(p_row[0])
	);
	ebv_angle_prep u_prep_y (
		.clk(clk), .en_s1(en[0]), .en_s2(en[1]), .angle(angles.yaw), .lane(y_row[0])
	);
	ebv_angle_prep u_prep_r (
		.clk(clk), .en_s1(en[0]), .en_s2(en[1]), .angle(angles.roll), .lane(r_row[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		ebv_cordic_cell #(.STAGE(g)) u_cell_p (
			.clk(clk), .en(en[g+2]), .lane_in(p_row[g]), .lane_out(p_row[g+1])
		);
		ebv_cordic_cell #(.STAGE(g)) u_cell_y (
			.clk(clk), .en(en[g+2]), .lane_in(y_row[g]), .lane_out(y_row[g+1])
		);
		ebv_cordic_cell #(.STAGE(g)) u_cell_r (
			.clk(clk), .en(en[g+2]), .lane_in(r_row[g]), .lane_out(r_row[g+1])
		);
	end

	ebv_basis #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_basis (
		.clk(clk),
		.en_s1(en[CORDIC_STAGES+2]),
		.en_s2(en[CORDIC_STAGES+3]),
		.en_s3(en[CORDIC_STAGES+4]),
		.p_lane(p_row[CORDIC_STAGES]),
		.y_lane(y_row[CORDIC_STAGES]),
		.r_lane(r_row[CORDIC_STAGES]),
		.basis(basis)
	);

`ifndef SYNTHESIS
	// a free output frees the whole chain
	a_free_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!basis_stall |-> !angles_stall) else $error("input stalled with output free");

	// an accepted item lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		angles_valid && !angles_stall |=> valid_q[0]) else $error("accepted item lost");

	// a waiting result is not dropped
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		basis_valid && basis_stall |=> basis_valid) else $error("stalled result dropped");
`endif

endmodule

[sim/ebv_checker.sv]
// ebv_checker: watches the angles and basis channels of euler_to_basis_vectors,
// predicts each basis item from the accepted angles and compares in order.
// Depends on ebv_pkg.
module ebv_checker #(
	parameter int CORDIC_STAGES = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             angles_valid,
	input  logic             angles_stall,
	input  ebv_pkg::angles_t angles,
	input  logic             basis_valid,
	input  logic             basis_stall,
	input  ebv_pkg::basis_t  basis,
	output int               fail_count,
	output int               pending,
	output int               seen
);
	import ebv_pkg::*;

	localparam int NST = CORDIC_STAGES > 32 ? 32 : (CORDIC_STAGES < 0 ? 0 : CORDIC_STAGES);
	localparam int OFR = OUT_FRAC_BITS > 30 ? 30 : (OUT_FRAC_BITS < 0 ? 0 : OUT_FRAC_BITS);

	basis_t expected_basis[$];

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return floor_shr(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic void angle_sin_cos(logic signed [15:0] deg, output longint s,
			output longint c);
		int r;
		longint u, z, x, y, t;
		bit flip;
		r = int'(deg) % DEG360_Q6;
		if (r < 0) r += DEG360_Q6;
		u = ((longint'(r) <<< 26) + 180) / 360;
		z = (u >= 64'sh80000000) ? u - (64'sd1 <<< 32) : u;
		flip = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31;
			flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31;
			flip = 1;
		end
		x = longint'(GAIN_Q30);
		y = 0;
		for (int i = 0; i < NST; i++) begin
			if (z >= 0) begin
				t = x - floor_shr(y, i);
				y = y + floor_shr(x, i);
				z -= longint'(ATAN_TBL[i]);
			end else begin
				t = x + floor_shr(y, i);
				y = y - floor_shr(x, i);
				z += longint'(ATAN_TBL[i]);
			end
			x = t;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic logic signed [15:0] to_component(longint v);
		longint one;
		int sh;
		sh = 30 - OFR;
		one = 64'sd1 <<< OFR;
		if (sh > 0) v = floor_shr(v + (64'sd1 <<< (sh - 1)), sh);
		if (v > one) v = one;
		if (v < -one) v = -one;
		return v[15:0];
	endfunction

	function automatic basis_t orientation_basis(angles_t a);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		basis_t b;
		angle_sin_cos(a.pitch, sp, cp);
		angle_sin_cos(a.yaw, sy, cy);
		angle_sin_cos(a.roll, sr, cr);
		srsp = round_q30(sr, sp);
		crsp = round_q30(cr, sp);
		b.forward_x = to_component(round_q30(cp, cy));
		b.forward_y = to_component(round_q30(cp, sy));
		b.forward_z = to_component(-sp);
		b.right_x = to_component(-round_q30(srsp, cy) + round_q30(cr, sy));
		b.right_y = to_component(-round_q30(srsp, sy) - round_q30(cr, cy));
		b.right_z = to_component(-round_q30(sr, cp));
		b.up_x = to_component(round_q30(crsp, cy) + round_q30(sr, sy));
		b.up_y = to_component(round_q30(crsp, sy) - round_q30(sr, cy));
		b.up_z = to_component(round_q30(cr, cp));
		return b;
	endfunction

	function automatic void compare_field(string name, logic signed [15:0] exp_v,
			logic signed [15:0] got_v, ref bit bad);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
			bad = 1;
		end
	endfunction

	always @(posedge clk) begin
		basis_t e;
		bit bad;
		if (!arst_n) begin
			fail_count = 0;
			seen = 0;
			expected_basis.delete();
		end else begin
			if (angles_valid && !angles_stall)
				expected_basis.push_back(orientation_basis(angles));
			if (basis_valid && !basis_stall) begin
				seen++;
				if (expected_basis.size() == 0) begin
					$display("%0t: unexpected basis item %h", $time, basis);
					fail_count++;
				end else begin
					e = expected_basis.pop_front();
					bad = 0;
					compare_field("forward_x", e.forward_x, basis.forward_x, bad);
					compare_field("forward_y", e.forward_y, basis.forward_y, bad);
					compare_field("forward_z", e.forward_z, basis.forward_z, bad);
					compare_field("right_x", e.right_x, basis.right_x, bad);
					compare_field("right_y", e.right_y, basis.right_y, bad);
					compare_field("right_z", e.right_z, basis.right_z, bad);
					compare_field("up_x", e.up_x, basis.up_x, bad);
					compare_field("up_y", e.up_y, basis.up_y, bad);
					compare_field("up_z", e.up_z, basis.up_z, bad);
					if (bad) fail_count++;
				end
			end
		end
		pending = expected_basis.size();
	end

endmodule

[sim/testbench.sv]
// testbench: stimulus and verdict for euler_to_basis_vectors; prediction and
// checking live in ebv_checker. Depends on ebv_pkg and the block's RTL.
module testbench;
	import ebv_pkg::*;

	localparam int LATENCY = 16 + 5;
	localparam int WATCHDOG_LIMIT = 2000;

	logic    clk;
	logic    arst_n;
	logic    angles_valid;
	logic    angles_stall;
	angles_t angles;
	logic    basis_valid;
	logic    basis_stall;
	basis_t  basis;
	int      fail_count;
	int      pending;
	int      seen;
	int      sent;
	int      send_gap_pct;   // chance in percent the sender skips a cycle
	int      stall_pct;      // chance in percent the receiver stalls
	int      idle_cycles;

	euler_to_basis_vectors uut (
		.clk(clk), .arst_n(arst_n),
		.angles_valid(angles_valid), .angles_stall(angles_stall), .angles(angles),
		.basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis)
	);

	ebv_checker chk (
		.clk(clk), .arst_n(arst_n),
		.angles_valid(angles_valid), .angles_stall(angles_stall), .angles(angles),
		.basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis),
		.fail_count(fail_count), .pending(pending), .seen(seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// receiver stall pattern, redrawn every cycle
	always @(posedge clk)
		basis_stall <= ($urandom_range(99) < stall_pct);

	// watchdog: cycles with no item accepted on either channel
	always @(posedge clk) begin
		if (!arst_n || (angles_valid && !angles_stall) || (basis_valid && !basis_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one item. Valid stays high across back-to-back items; when
	// the sender idles it is lowered for the gap cycles first. Returns after
	// the item has been accepted.
	task automatic send_angles(logic signed [15:0] p, logic signed [15:0] y,
			logic signed [15:0] r);
		while ($urandom_range(99) < send_gap_pct) begin
			angles_valid <= 1'b0;
			@(posedge clk);
		end
		angles_valid <= 1'b1;
		angles <= '{pitch: p, yaw: y, roll: r};
		@(posedge clk);
		while (angles_stall) @(posedge clk);
		sent++;
	endtask

	// angles near multiples of 90 degrees, where the CORDIC fold kicks in
	function automatic logic signed [15:0] edge_angle();
		int q;
		q = $urandom_range(8) - 4;
		return 16'(q * 90 * 64 + int'($urandom_range(8)) - 4);
	endfunction

	function automatic logic signed [15:0] any_angle();
		case ($urandom_range(3))
			0: return edge_angle();
			1: return 16'($urandom_range(23040) - 11520);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(int n, int gap_pct, int st_pct);
		send_gap_pct = gap_pct;
		stall_pct = st_pct;
		repeat (n) send_angles(any_angle(), any_angle(), any_angle());
	endtask

	initial begin
		arst_n = 1'b0;
		angles_valid = 1'b0;
		angles = '0;
		send_gap_pct = 0;
		stall_pct = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero, wrap points, the +/-90 fold and
		// the region past it, and the degenerate pitch poles
		send_angles(16'sd0, 16'sd0, 16'sd0);
		send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_angles(-16'sh8000, -16'sh8000, -16'sh8000);
		send_angles(16'sh7fff, -16'sh8000, 16'sd0);
		send_angles(-16'sd1, 16'sd1, -16'sd1);
		send_angles(16'sd5760, 16'sd0, 16'sd0);      // pitch 90
		send_angles(-16'sd5760, 16'sd5760, 16'sd5760);
		send_angles(16'sd5761, 16'sd5759, -16'sd5761);
		send_angles(16'sd11520, -16'sd11520, 16'sd11520); // 180
		send_angles(16'sd17280, 16'sd17280, -16'sd17280); // 270
		send_angles(16'sd23040, -16'sd23040, 16'sd23039); // 360 wrap
		send_angles(16'sd2880, 16'sd8640, 16'sd14400);
		send_angles(-16'sd2880, -16'sd8640, -16'sd14400);
		send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
		send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
		send_angles(16'sd1920, 16'sd3840, 16'sd960);

		// sender gaps light, receiver stalls heavy; then swapped; then none
		random_phase(380, 13, 50);
		random_phase(380, 50, 13);
		random_phase(380, 0, 0);
		angles_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d orientations (directed corners and random angles), checked %0d",
			sent, seen);
		$display("basis items across three idle/stall mixes");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
